/* rtl/rfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types for the ring FIFO with peek: operation codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rfp_pkg;

   typedef enum logic [1:0] {
      FUNC_PUSH     = 2'd0,
      FUNC_POP      = 2'd1,
      FUNC_POP_MANY = 2'd2,
      FUNC_PEEK     = 2'd3
   } func_type;

   typedef struct packed {
      logic latch_req;
      logic issue_rd;
      logic emit_exec;
      logic emit_rd;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_read;
      logic last_beat;
      logic out_free;
   } dp_sts_type;

endpackage

/* rtl/rfp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_ctrl
// Sequencer: takes a request and executes it; a request that reads then
// streams read beats out of the slot memory until the run ends.
// ----------------------------------------------------------------------------
module rfp_ctrl
   import rfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.need_read) begin
               cmd.issue_rd = 1'b1;
               state_in     = ST_READ;
            end else if (sts.out_free) begin
               cmd.emit_exec = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            if (sts.out_free) begin
               cmd.emit_rd = 1'b1;
               if (sts.last_beat) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/rfp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_datapath
// Slot memory, head and tail pointers, size register, request latch
// and the result register.
// ----------------------------------------------------------------------------
module rfp_datapath
   import rfp_pkg::*;
#(
   parameter int DEPTH         = 64,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_size_log2,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_push_word,
   input  logic [5:0]  req_pop_count,
   input  logic [5:0]  req_peek_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_read_word,
   output logic        rsp_last,
   output logic [5:0]  rsp_fill_level,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts
);

   localparam int LG_FLOOR = $clog2(DEPTH + 1) - 1;
   localparam int LG_MAX   = (LG_FLOOR > 7) ? 7 : LG_FLOOR;
   localparam int IW       = LG_MAX;
   localparam int ENTRIES  = 1 << IW;
   localparam int EW       = ELEMENT_WIDTH;

   logic [EW-1:0] mem [ENTRIES];

   logic [2:0]    size_lg_ff;
   logic [IW-1:0] head_ff;
   logic [IW-1:0] head_in;
   logic [IW-1:0] tail_ff;
   logic [IW-1:0] tail_in;
   func_type      func_ff;
   logic [31:0]   word_ff;
   logic [5:0]    count_ff;
   logic [5:0]    offset_ff;
   logic [5:0]    remain_ff;
   logic [5:0]    remain_in;
   logic [EW-1:0] rd_ff;

   logic          rsp_valid_ff;
   logic          rsp_ok_ff;
   logic          rsp_ok_in;
   logic [31:0]   rsp_word_ff;
   logic [31:0]   rsp_word_in;
   logic          rsp_last_ff;
   logic          rsp_last_in;
   logic [5:0]    rsp_fill_ff;
   logic [5:0]    rsp_fill_in;

   logic [2:0]    eff_lg;
   logic [7:0]    mask_full;
   logic [IW-1:0] mask;
   logic [IW-1:0] used;
   logic [IW-1:0] tail_next;
   logic [IW-1:0] head_next;
   logic [IW-1:0] peek_addr;
   logic [IW-1:0] rd_addr;
   logic          full;
   logic [6:0]    used7;
   logic [6:0]    count7;
   logic [6:0]    offset7;
   logic [6:0]    n7;
   logic          need_read;
   logic          last_beat;
   logic          out_free;
   logic          rd_en;
   logic          wr_en;
   logic [63:0]   push_ext;
   logic [63:0]   rd_ext;

   // effective ring size, clamped into range
   always_comb begin
      if (size_lg_ff == 3'd0) begin
         eff_lg = 3'd1;
      end else if (size_lg_ff > 3'(LG_MAX)) begin
         eff_lg = 3'(LG_MAX);
      end else begin
         eff_lg = size_lg_ff;
      end
   end

   assign mask_full = (8'd1 << eff_lg) - 8'd1;
   assign mask      = mask_full[IW-1:0];
   assign used      = (tail_ff - head_ff) & mask;
   assign tail_next = (tail_ff + IW'(1)) & mask;
   assign head_next = (head_ff + IW'(1)) & mask;
   assign peek_addr = (head_ff + IW'(offset_ff)) & mask;
   assign full      = (tail_next == head_ff);
   assign used7     = 7'(used);
   assign count7    = {1'b0, count_ff};
   assign offset7   = {1'b0, offset_ff};
   assign n7        = (count7 < used7) ? count7 : used7;

   always_comb begin
      case (func_ff)
         FUNC_POP:      need_read = (used7 != 7'd0);
         FUNC_POP_MANY: need_read = (n7 != 7'd0);
         FUNC_PEEK:     need_read = (offset7 < used7);
         default:       need_read = 1'b0;
      endcase
   end

   assign last_beat = (remain_ff == 6'd1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign sts.need_read = need_read;
   assign sts.last_beat = last_beat;
   assign sts.out_free  = out_free;

   assign wr_en   = cmd.emit_exec && (func_ff == FUNC_PUSH) && !full;
   assign rd_en   = cmd.issue_rd || (cmd.emit_rd && !last_beat);
   assign rd_addr = cmd.emit_rd ? head_next :
                    ((func_ff == FUNC_PEEK) ? peek_addr : head_ff);

   assign push_ext = {32'd0, word_ff};

   always_comb begin
      rd_ext         = '0;
      rd_ext[EW-1:0] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= push_ext[EW-1:0];
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // pointer and result next state
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      remain_in   = remain_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;
      rsp_fill_in = rsp_fill_ff;
      if (cmd.issue_rd) begin
         remain_in = (func_ff == FUNC_POP_MANY) ? n7[5:0] : 6'd1;
      end
      if (cmd.emit_exec) begin
         rsp_word_in = 32'd0;
         rsp_last_in = 1'b1;
         rsp_ok_in   = 1'b0;
         rsp_fill_in = 6'(used);
         if (func_ff == FUNC_PUSH && !full) begin
            tail_in     = tail_next;
            rsp_ok_in   = 1'b1;
            rsp_fill_in = 6'((tail_next - head_ff) & mask);
         end
      end
      if (cmd.emit_rd) begin
         rsp_ok_in   = 1'b1;
         rsp_word_in = rd_ext[31:0];
         rsp_last_in = last_beat;
         remain_in   = remain_ff - 6'd1;
         if (func_ff == FUNC_PEEK) begin
            rsp_fill_in = 6'(used);
         end else begin
            head_in     = head_next;
            rsp_fill_in = 6'((tail_ff - head_next) & mask);
         end
      end
      if (csr_write) begin
         head_in = '0;
         tail_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_lg_ff   <= 3'd6;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            size_lg_ff <= csr_size_log2;
         end
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (cmd.emit_exec || cmd.emit_rd) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff   <= func_type'(req_func);
         word_ff   <= req_push_word;
         count_ff  <= req_pop_count;
         offset_ff <= req_peek_offset;
      end
      remain_ff   <= remain_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_level = rsp_fill_ff;

endmodule

/* rtl/ring_fifo_with_peek_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_with_peek_unit
// Circular FIFO with push, pop, pop-many and peek-at-offset requests.
// ----------------------------------------------------------------------------
// A ring of 2^size_log2 slots (clamped to 1..floor(log2 DEPTH), at most 7)
// holding up to size-1 words. Each request gives one response beat, except a
// successful pop-many, which gives one beat per word with rsp_last on the
// final one. A push or any failing request is answered from the execute step;
// a pop, peek or pop-many first reads the slot memory through its registered
// read port, then gives one beat per cycle while the response register is
// free. A new request is taken once the previous one has handed off its last
// beat to the response register. Writing csr_size_log2 empties the FIFO;
// write it only while no request is in flight.
module ring_fifo_with_peek_unit
   import rfp_pkg::*;
#(
   parameter int DEPTH         = 64,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_size_log2,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_push_word,
   input  logic [5:0]  req_pop_count,
   input  logic [5:0]  req_peek_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_read_word,
   output logic        rsp_last,
   output logic [5:0]  rsp_fill_level
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   assign csr_ready = 1'b1;

   rfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfp_datapath #(
      .DEPTH         (DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_size_log2   (csr_size_log2),
      .req_func        (req_func),
      .req_push_word   (req_push_word),
      .req_pop_count   (req_pop_count),
      .req_peek_offset (req_peek_offset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_read_word   (rsp_read_word),
      .rsp_last        (rsp_last),
      .rsp_fill_level  (rsp_fill_level),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule
